>>> rtl/uets_pkg.sv
package uets_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 64;
  localparam int unsigned ENDPOINTS_DEF        = 16;

  // bmRequestType direction bit
  localparam logic [7:0] DIR_IN_MASK = 8'h80;

  typedef enum logic [2:0] {
    FN_OPEN       = 3'd0,
    FN_START_IN   = 3'd1,
    FN_IN_ACKED   = 3'd2,
    FN_IN_NAKED   = 3'd3,
    FN_SETUP      = 3'd4,
    FN_PREP_OUT   = 3'd5,
    FN_OUT_PACKET = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_SEND       = 3'd1,
    ACT_REQ_IN     = 3'd2,
    ACT_OUT_DATA   = 3'd3,
    ACT_SETUP_DONE = 3'd4
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [31:0] base;
    logic [15:0] total;
    logic [15:0] acked;
    logic        toggle;
    logic        zlp;
  } in_rec_t;

  typedef struct packed {
    logic [15:0] total;
    logic [15:0] received;
  } out_rec_t;

  typedef struct packed {
    func_t       func;
    logic [3:0]  endpoint;
    logic [15:0] length;
    logic [31:0] buffer_base;
    logic        setup_direction_in;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic [3:0]  out_endpoint;
    logic        data_toggle;
    logic [31:0] packet_address;
    logic [6:0]  packet_length;
    logic        rx_release;
    logic [15:0] received_total;
    logic        out_complete;
    logic        out_overrun;
  } result_t;

  localparam int unsigned IN_REC_W  = $bits(in_rec_t);
  localparam int unsigned OUT_REC_W = $bits(out_rec_t);

endpackage

>>> rtl/uets_rec_mem.sv
module uets_rec_mem #(
  parameter int unsigned DEPTH = uets_pkg::ENDPOINTS_DEF,
  parameter int unsigned WIDTH = uets_pkg::IN_REC_W,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      // entries not yet written read as their reset value
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

>>> rtl/uets_update.sv
module uets_update #(
  parameter int unsigned MAX_PACKET_BYTES = uets_pkg::MAX_PACKET_BYTES_DEF,
  parameter int unsigned ENDPOINTS        = uets_pkg::ENDPOINTS_DEF
) (
  input  uets_pkg::item_t    item,
  input  uets_pkg::in_rec_t  in_rec,
  input  uets_pkg::out_rec_t out_rec,
  output uets_pkg::in_rec_t  in_rec_next,
  output logic               in_we,
  output uets_pkg::out_rec_t out_rec_next,
  output logic               out_we,
  output uets_pkg::result_t  result
);

  logic        in_range;
  logic        ep_zero;
  logic [15:0] remain;
  logic [15:0] chunk;
  logic [16:0] sum;
  logic [15:0] got;
  logic        done;
  logic [7:0]  dir_byte;

  assign in_range = 5'(item.endpoint) < 5'(ENDPOINTS);
  assign ep_zero  = item.endpoint == 4'd0;
  assign remain   = (in_rec.total > in_rec.acked) ? (in_rec.total - in_rec.acked) : 16'd0;
  assign chunk    = (remain > 16'(MAX_PACKET_BYTES)) ? 16'(MAX_PACKET_BYTES) : remain;
  assign sum      = {1'b0, out_rec.received} + {1'b0, item.length};
  assign got      = sum[15:0];
  assign done     = got == out_rec.total;
  assign dir_byte = {item.setup_direction_in, 7'd0};

  always_comb begin
    in_rec_next         = in_rec;
    out_rec_next        = out_rec;
    in_we               = 1'b0;
    out_we              = 1'b0;
    result              = '0;
    result.action       = uets_pkg::ACT_NONE;
    result.out_endpoint = item.endpoint;
    if (in_range) begin
      unique case (item.func)
        uets_pkg::FN_OPEN: begin
          in_rec_next.toggle = ep_zero;
          in_we              = 1'b1;
        end
        uets_pkg::FN_START_IN: begin
          in_rec_next.base  = item.buffer_base;
          in_rec_next.total = item.length;
          in_rec_next.acked = '0;
          in_rec_next.zlp   = item.length == 16'd0;
          in_we             = 1'b1;
        end
        uets_pkg::FN_IN_ACKED: begin
          in_rec_next.acked  = in_rec.acked + chunk;
          in_rec_next.toggle = ~in_rec.toggle;
          in_rec_next.zlp    = 1'b0;
          in_we              = 1'b1;
        end
        uets_pkg::FN_IN_NAKED: begin
          if (in_rec.zlp || (in_rec.acked != in_rec.total)) begin
            result.action         = uets_pkg::ACT_SEND;
            result.data_toggle    = in_rec.toggle;
            result.packet_address = in_rec.base + {16'd0, in_rec.acked};
            result.packet_length  = chunk[6:0];
          end else begin
            result.action = uets_pkg::ACT_REQ_IN;
          end
        end
        uets_pkg::FN_SETUP: begin
          if (ep_zero) begin
            in_rec_next.toggle = 1'b1;
            in_we              = 1'b1;
            result.action      = uets_pkg::ACT_SETUP_DONE;
            // host-to-device with payload keeps the out side as it is
            if (!(((dir_byte & uets_pkg::DIR_IN_MASK) == 8'd0) && (item.length != 16'd0))) begin
              out_rec_next      = '0;
              out_we            = 1'b1;
              result.rx_release = 1'b1;
            end
          end
        end
        uets_pkg::FN_PREP_OUT: begin
          out_rec_next.total    = item.length;
          out_rec_next.received = '0;
          out_we                = 1'b1;
          result.rx_release     = 1'b1;
        end
        uets_pkg::FN_OUT_PACKET: begin
          out_rec_next.received = got;
          out_we                = 1'b1;
          result.action         = uets_pkg::ACT_OUT_DATA;
          result.received_total = got;
          result.out_complete   = done;
          result.out_overrun    = sum[16] || (got > out_rec.total);
          if (ep_zero && done) begin
            out_rec_next      = '0;
            result.rx_release = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/usb_endpoint_transfer_segmenter.sv
// result: once an item is accepted its records are read; the result is loaded
//   in the EXEC state once the result register is free; a new item is taken only
//   after the last one's records are read and written back (read, then update)
// reset: synchronous, active high; clears per-entry valid bits of both record
//   memories at once so every endpoint reads as zero, no clearing pass needed
module usb_endpoint_transfer_segmenter #(
  parameter int unsigned MAX_PACKET_BYTES = uets_pkg::MAX_PACKET_BYTES_DEF,
  parameter int unsigned ENDPOINTS        = uets_pkg::ENDPOINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // endpoint[3:0], length[19:4], buffer_base[51:20], setup_direction_in[52], zero pad
  input  logic [55:0] s_axis_tdata,
  // func[2:0]
  input  logic [2:0]  s_axis_tuser,
  // result item channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_endpoint[3:0], data_toggle[4], packet_address[36:5], packet_length[43:37],
  // rx_release[44], received_total[60:45], out_complete[61], out_overrun[62], zero pad
  output logic [63:0] m_axis_tdata,
  // action[2:0]
  output logic [2:0]  m_axis_tuser
);

  localparam int unsigned AW = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;

  uets_pkg::state_t   state;
  uets_pkg::state_t   state_next;
  uets_pkg::item_t    item;
  uets_pkg::in_rec_t  in_rec;
  uets_pkg::in_rec_t  in_rec_next;
  uets_pkg::out_rec_t out_rec;
  uets_pkg::out_rec_t out_rec_next;
  uets_pkg::result_t  result;
  uets_pkg::result_t  result_reg;
  logic               in_we;
  logic               out_we;
  logic               accept;
  logic               commit;
  logic               out_free;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign rd_addr  = s_axis_tdata[AW-1:0];
  assign wr_addr  = item.endpoint[AW-1:0];

  // sequencer: wait for an item, then update its record once the result slot frees
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uets_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    unique case (state)
      uets_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = uets_pkg::ST_EXEC;
        end
      end
      uets_pkg::ST_EXEC: begin
        // record data is valid here; write back and load the result together
        if (out_free) begin
          commit     = 1'b1;
          state_next = uets_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = uets_pkg::ST_IDLE;
      end
    endcase
  end

  // hold the item while its records are read
  always_ff @(posedge clk) begin
    if (accept) begin
      item.func               <= uets_pkg::func_t'(s_axis_tuser);
      item.endpoint           <= s_axis_tdata[3:0];
      item.length             <= s_axis_tdata[19:4];
      item.buffer_base        <= s_axis_tdata[51:20];
      item.setup_direction_in <= s_axis_tdata[52];
    end
  end

  // in-transfer records per endpoint
  uets_rec_mem #(
    .DEPTH (ENDPOINTS),
    .WIDTH (uets_pkg::IN_REC_W)
  ) u_in_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (in_rec),
    .wr_en   (commit && in_we),
    .wr_addr (wr_addr),
    .wr_data (in_rec_next)
  );

  // out-transfer records per endpoint
  uets_rec_mem #(
    .DEPTH (ENDPOINTS),
    .WIDTH (uets_pkg::OUT_REC_W)
  ) u_out_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (out_rec),
    .wr_en   (commit && out_we),
    .wr_addr (wr_addr),
    .wr_data (out_rec_next)
  );

  // event decode and record update
  uets_update #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .ENDPOINTS        (ENDPOINTS)
  ) u_update (
    .item         (item),
    .in_rec       (in_rec),
    .out_rec      (out_rec),
    .in_rec_next  (in_rec_next),
    .in_we        (in_we),
    .out_rec_next (out_rec_next),
    .out_we       (out_we),
    .result       (result)
  );

  // result register, holds until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result_reg <= result;
    end
  end

  assign m_axis_tuser = result_reg.action;
  assign m_axis_tdata = {
    1'b0,
    result_reg.out_overrun,
    result_reg.out_complete,
    result_reg.received_total,
    result_reg.rx_release,
    result_reg.packet_length,
    result_reg.packet_address,
    result_reg.data_toggle,
    result_reg.out_endpoint
  };

endmodule
